// ===== hw/rtl/locidx_pkg.sv =====
// Package for the linear octree cell index unit: field widths, word and
// stage types shared by the pipeline modules. No dependencies.
package locidx_pkg;

   localparam int COORD_W         = 8;
   localparam int LEVEL_W         = 4;
   localparam int CODE_W          = 3 * COORD_W;
   localparam int INDEX_W         = 25;
   localparam int DEF_MAX_LEVELS  = 8;
   localparam logic [LEVEL_W-1:0] LEVELS_RESET = 4'd8;

   typedef struct packed {
      logic [COORD_W-1:0] min_x;
      logic [COORD_W-1:0] min_y;
      logic [COORD_W-1:0] min_z;
      logic [COORD_W-1:0] max_x;
      logic [COORD_W-1:0] max_y;
      logic [COORD_W-1:0] max_z;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] cell_index;
      logic [LEVEL_W-1:0] cell_level;
      logic               out_of_range;
   } rsp_type;

   // stage 1 -> stage 2
   typedef struct packed {
      logic               valid;
      logic               oor;
      logic [LEVEL_W-1:0] lv;
      logic [CODE_W-1:0]  lo;
      logic [CODE_W-1:0]  diff;
   } s1_type;

   // stage 2 -> stage 3
   typedef struct packed {
      logic               valid;
      logic               oor;
      logic [LEVEL_W-1:0] level;
      logic [CODE_W-1:0]  prefix;
   } s2_type;

endpackage

// ===== hw/rtl/linear_octree_cell_index_unit.sv =====
// Linear octree cell index unit, top level: level register, three-stage
// pipeline. Depends on locidx_pkg, locidx_interleave, locidx_prefix, locidx_offset_add.
//
// Takes one box word per cycle while busy is low (min/max corner grid cells)
// and returns the deepest octree level whose cell holds the whole box and
// that cell's linear index (Morton prefix plus the count of cells in
// shallower levels). Throughput is one word per clock while busy is low; the
// result is registered in the three pipeline registers: interleave, group
// search/shift, offset add. busy is high only during reset. The result word
// appears for exactly one cycle with rsp_strobe and cannot be held off, so
// the receiver must capture it then. A coordinate of 2^levels or more gives
// out_of_range with index and level 0. levels is written through the csr
// channel (always ready); 0 behaves as 1 and values above MAX_LEVELS behave
// as MAX_LEVELS. Write levels only with the pipeline empty.
module linear_octree_cell_index_unit #(
   parameter int MAX_LEVELS = locidx_pkg::DEF_MAX_LEVELS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            start,
   output logic                            busy,
   input  locidx_pkg::req_type             req_data,
   // result channel
   output logic                            rsp_strobe,
   output locidx_pkg::rsp_type             rsp_data,
   // levels register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [locidx_pkg::LEVEL_W-1:0]  csr_wdata
);
   import locidx_pkg::*;

   logic [LEVEL_W-1:0] levels_ff;
   logic               accept;
   s1_type             s1;
   s2_type             s2;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
      end else if (csr_valid && csr_ready) begin
         levels_ff <= csr_wdata;
      end
   end

   // stage 1: clamp, range check, interleave
   locidx_interleave #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_interleave (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .req      (req_data),
      .levels   (levels_ff),
      .s1       (s1)
   );

   // stage 2: highest differing group, level, prefix shift
   locidx_prefix u_prefix (
      .clock (clock),
      .reset (reset),
      .s1    (s1),
      .s2    (s2)
   );

   // stage 3: offset add, output register
   locidx_offset_add u_offset_add (
      .clock      (clock),
      .reset      (reset),
      .s2         (s2),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // every taken word comes out with rsp_strobe after the three pipeline registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("result missing three cycles after accept");

   // no result without a matching word taken earlier through the pipeline
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 3))
      else $error("result strobe without matching request");

   // out of range results carry zero index and level
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.out_of_range) |->
         (rsp_data.cell_index == '0 && rsp_data.cell_level == '0))
      else $error("out_of_range result with nonzero fields");

   // reported level never exceeds the clamped level count
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.cell_level <= LEVEL_W'(MAX_LEVELS)))
      else $error("cell_level above MAX_LEVELS");

endmodule

// ===== hw/rtl/locidx_interleave.sv =====
// Stage 1: level clamp, range check and Morton interleave of both corners.
// Depends on locidx_pkg.
module locidx_interleave #(
   parameter int MAX_LEVELS = locidx_pkg::DEF_MAX_LEVELS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  locidx_pkg::req_type               req,
   input  logic [locidx_pkg::LEVEL_W-1:0]    levels,
   output locidx_pkg::s1_type                s1
);
   import locidx_pkg::*;

   localparam logic [LEVEL_W-1:0] MAX_LV = LEVEL_W'(MAX_LEVELS);

   function automatic logic [CODE_W-1:0] spread3(input logic [COORD_W-1:0] v);
      logic [CODE_W-1:0] r;
      r = '0;
      for (int k = 0; k < COORD_W; k++) begin
         r[3*k] = v[k];
      end
      return r;
   endfunction

   logic               valid_ff;
   logic [LEVEL_W-1:0] lv_in;
   logic               oor_in;
   logic [CODE_W-1:0]  lo_in;
   logic [CODE_W-1:0]  hi_in;
   s1_type             data_ff;

   always_comb begin
      lv_in = levels;
      if (lv_in == '0) begin
         lv_in = LEVEL_W'(1);
      end
      if (lv_in > MAX_LV) begin
         lv_in = MAX_LV;
      end
      oor_in = ((req.min_x >> lv_in) != '0) || ((req.min_y >> lv_in) != '0) ||
               ((req.min_z >> lv_in) != '0) || ((req.max_x >> lv_in) != '0) ||
               ((req.max_y >> lv_in) != '0) || ((req.max_z >> lv_in) != '0);
      lo_in = spread3(req.min_x) | (spread3(req.min_y) << 1) | (spread3(req.min_z) << 2);
      hi_in = spread3(req.max_x) | (spread3(req.max_y) << 1) | (spread3(req.max_z) << 2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff.valid <= 1'b0;
      data_ff.oor   <= oor_in;
      data_ff.lv    <= lv_in;
      data_ff.lo    <= lo_in;
      data_ff.diff  <= lo_in ^ hi_in;
   end

   always_comb begin
      s1       = data_ff;
      s1.valid = valid_ff;
   end

endmodule

// ===== hw/rtl/locidx_prefix.sv =====
// Stage 2: find highest differing 3-bit group, derive level and code prefix.
// Depends on locidx_pkg.
module locidx_prefix (
   input  logic                clock,
   input  logic                reset,
   input  locidx_pkg::s1_type  s1,
   output locidx_pkg::s2_type  s2
);
   import locidx_pkg::*;

   localparam int NUM_GROUPS = CODE_W / 3;

   logic               valid_ff;
   logic [LEVEL_W-1:0] groups;
   logic [4:0]         shamt;
   s2_type             data_ff;

   // groups = count of low groups up to and including the highest one that differs
   always_comb begin
      groups = '0;
      for (int k = 0; k < NUM_GROUPS; k++) begin
         if (|s1.diff[3*k +: 3]) begin
            groups = LEVEL_W'(k + 1);
         end
      end
      shamt = 5'(groups) + 5'({groups, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s1.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff.valid  <= 1'b0;
      data_ff.oor    <= s1.oor;
      data_ff.level  <= s1.lv - groups;
      data_ff.prefix <= s1.lo >> shamt;
   end

   always_comb begin
      s2       = data_ff;
      s2.valid = valid_ff;
   end

endmodule

// ===== hw/rtl/locidx_offset_add.sv =====
// Stage 3: add the per-level cell offset and register the result word.
// Depends on locidx_pkg.
module locidx_offset_add (
   input  logic                clock,
   input  logic                reset,
   input  locidx_pkg::s2_type  s2,
   output logic                rsp_strobe,
   output locidx_pkg::rsp_type rsp_data
);
   import locidx_pkg::*;

   // (8^level - 1) / 7: cells in all shallower levels, low 25 bits
   function automatic logic [INDEX_W-1:0] level_offset(input logic [LEVEL_W-1:0] level);
      logic [31:0] off;
      case (level)
         4'd0:    off = 32'd0;
         4'd1:    off = 32'd1;
         4'd2:    off = 32'd9;
         4'd3:    off = 32'd73;
         4'd4:    off = 32'd585;
         4'd5:    off = 32'd4681;
         4'd6:    off = 32'd37449;
         4'd7:    off = 32'd299593;
         4'd8:    off = 32'd2396745;
         4'd9:    off = 32'd19173961;
         4'd10:   off = 32'd153391689;
         default: off = 32'd0;
      endcase
      return off[INDEX_W-1:0];
   endfunction

   logic    strobe_ff;
   rsp_type rsp_in;
   rsp_type rsp_ff;

   always_comb begin
      if (s2.oor) begin
         rsp_in.cell_index   = '0;
         rsp_in.cell_level   = '0;
         rsp_in.out_of_range = 1'b1;
      end else begin
         rsp_in.cell_index   = INDEX_W'(s2.prefix) + level_offset(s2.level);
         rsp_in.cell_level   = s2.level;
         rsp_in.out_of_range = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= s2.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== tb/tb_linear_octree_cell_index_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for linear_octree_cell_index_unit: directed box table,
// then random phases at several levels settings. Depends on locidx_pkg and the RTL.
module tb_linear_octree_cell_index_unit;
   import locidx_pkg::*;

   // upper bound of the levels value as the block sees it once clamped to 1..MAX_LEVELS
   localparam int MAX_LV = DEF_MAX_LEVELS;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   req_type             req_data;
   logic                rsp_strobe;
   rsp_type             rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [LEVEL_W-1:0]  csr_wdata;

   linear_octree_cell_index_unit #(
      .MAX_LEVELS (MAX_LV)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Expected result words, oldest first; one per accepted box word.
   rsp_type pending_cells[$];
   int      mismatch_count = 0;
   // Our copy of the levels register, as written (not clamped).
   logic [LEVEL_W-1:0] levels_reg = LEVELS_RESET;

   // One row of the directed table. "typed" rows carry a hand-worked answer.
   typedef struct {
      logic [LEVEL_W-1:0] lv;
      req_type            box;
      bit                 typed;
      rsp_type            want;
   } box_row_type;

   box_row_type box_table[$];

   function automatic int clamp_levels(input logic [LEVEL_W-1:0] lv);
      if (lv == 0) return 1;
      if (lv > MAX_LV) return MAX_LV;
      return int'(lv);
   endfunction

   // Coordinate bit k lands on code bit 3k; y and z are shifted in by the caller.
   function automatic logic [CODE_W-1:0] spread_coord(input logic [COORD_W-1:0] v);
      logic [CODE_W-1:0] r;
      r = '0;
      for (int k = 0; k < COORD_W; k++) r[3*k] = v[k];
      return r;
   endfunction

   // Smallest octree cell holding the box, for the given levels register.
   function automatic rsp_type predict_cell(input req_type b, input logic [LEVEL_W-1:0] lv_reg);
      rsp_type           r;
      int                lv;
      int                groups;
      int                depth;
      logic [CODE_W-1:0] lo;
      logic [CODE_W-1:0] hi;
      logic [CODE_W-1:0] diff;
      logic [31:0]       offset;
      logic [31:0]       idx;
      lv = clamp_levels(lv_reg);
      r  = '0;
      if ((b.min_x >> lv) != 0 || (b.min_y >> lv) != 0 || (b.min_z >> lv) != 0 ||
          (b.max_x >> lv) != 0 || (b.max_y >> lv) != 0 || (b.max_z >> lv) != 0) begin
         r.out_of_range = 1'b1;
         return r;
      end
      lo = spread_coord(b.min_x) | (spread_coord(b.min_y) << 1) | (spread_coord(b.min_z) << 2);
      hi = spread_coord(b.max_x) | (spread_coord(b.max_y) << 1) | (spread_coord(b.max_z) << 2);
      diff = lo ^ hi;
      // groups = count of 3-bit groups up to and including the top differing one
      groups = 0;
      for (int g = 0; g < COORD_W; g++)
         if (diff[3*g +: 3] != 3'b000) groups = g + 1;
      depth  = lv - groups;
      // cells in all shallower levels: 1 + 8 + ... + 8^(depth-1)
      offset = ((32'd1 << (3 * depth)) - 32'd1) / 32'd7;
      idx    = 32'(lo >> (3 * groups)) + offset;
      r.cell_index = idx[INDEX_W-1:0];
      r.cell_level = LEVEL_W'(depth);
      return r;
   endfunction

   task automatic add_row(input int lv, input int mnx, input int mny, input int mnz,
                          input int mxx, input int mxy, input int mxz,
                          input bit typed, input int idx, input int lvl, input bit oor);
      box_row_type row;
      row.lv    = LEVEL_W'(lv);
      row.box   = {COORD_W'(mnx), COORD_W'(mny), COORD_W'(mnz),
                   COORD_W'(mxx), COORD_W'(mxy), COORD_W'(mxz)};
      row.typed = typed;
      row.want  = {INDEX_W'(idx), LEVEL_W'(lvl), oor};
      box_table.push_back(row);
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Random box: mostly a well-formed box that shares high Morton groups,
   // some fully random words and some with one coordinate past the grid.
   function automatic req_type make_box(input logic [LEVEL_W-1:0] lv_reg);
      logic [COORD_W-1:0] c[6];
      int                 lv;
      int                 k;
      int                 sel;
      int                 lim;
      lv  = clamp_levels(lv_reg);
      lim = (1 << lv) - 1;
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
         for (int i = 0; i < 6; i++) c[i] = COORD_W'($urandom);
      end else begin
         k = $urandom_range(0, lv);
         for (int i = 0; i < 3; i++) begin
            c[i]     = COORD_W'($urandom_range(0, lim));
            c[i + 3] = c[i] ^ COORD_W'($urandom & ((1 << k) - 1));
            // swap corners now and then; the level must not care
            if ($urandom_range(0, 7) == 0) begin
               c[i + 3] = c[i];
               c[i]     = c[i] ^ COORD_W'($urandom & ((1 << k) - 1));
            end
         end
         if (sel < 25 && lv < MAX_LV)
            c[$urandom_range(0, 5)] = COORD_W'($urandom_range(lim + 1, 255));
      end
      return {c[0], c[1], c[2], c[3], c[4], c[5]};
   endfunction

   // Offer one box word after an optional gap; start stays up across back-to-back words.
   task automatic send_box(input req_type b, input rsp_type want, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (busy);
      pending_cells.push_back(want);
   endtask

   // Hold off new words until every expected result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
   endtask

   task automatic write_levels(input logic [LEVEL_W-1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      levels_reg  = v;
   endtask

   // Result checker: every strobe must match the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_cells.size() == 0) begin
            $error("unexpected result word: index %0d level %0d oor %0b",
                   rsp_data.cell_index, rsp_data.cell_level, rsp_data.out_of_range);
            mismatch_count++;
         end else begin
            want = pending_cells.pop_front();
            if (rsp_data.cell_index !== want.cell_index) begin
               $error("cell_index: expected %0d, actual %0d",
                      want.cell_index, rsp_data.cell_index);
               mismatch_count++;
            end
            if (rsp_data.cell_level !== want.cell_level) begin
               $error("cell_level: expected %0d, actual %0d",
                      want.cell_level, rsp_data.cell_level);
               mismatch_count++;
            end
            if (rsp_data.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0b, actual %0b",
                      want.out_of_range, rsp_data.out_of_range);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [LEVEL_W-1:0] phase_lv[$];
      int                 n_items;
      bit                 no_gaps;
      req_type            b;

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table. First rows rely on the reset value of levels (8).
      //        lv  min x  y   z   max x  y   z  typed  index     lvl oor
      add_row(8,   0,   0,   0,   0,   0,   0, 1, 2396745,  8, 0);  // equal corners at 0
      add_row(8, 255, 255, 255, 255, 255, 255, 1, 19173960, 8, 0);  // largest index
      add_row(8,   0,   0,   0, 255, 255, 255, 1, 0,        0, 0);  // whole grid: root
      add_row(8, 255, 255, 255,   0,   0,   0, 1, 0,        0, 0);  // corners swapped
      add_row(8,   0,   0,   0,   1,   0,   0, 1, 299593,   7, 0);  // differ in lowest x bit
      add_row(8, 128,  64,  32, 130,  64,  33, 0, 0,        0, 0);
      add_row(1,   2,   0,   0,   0,   0,   0, 1, 0,        0, 1);  // past a 2-cell grid
      add_row(1,   0,   0,   0,   0,   0,   1, 1, 0,        0, 0);
      add_row(1,   1,   1,   1,   1,   1,   1, 1, 8,        1, 0);
      add_row(0,   1,   1,   1,   1,   1,   1, 1, 8,        1, 0);  // levels 0 acts as 1
      add_row(0,   0,   0,   0,   0,   2,   0, 1, 0,        0, 1);
      add_row(15, 255, 255, 255, 255, 255, 255, 1, 19173960, 8, 0); // clamped to 8
      add_row(15,  17, 200,  99,  16, 201,  98, 0, 0,        0, 0);
      add_row(4,  16,   0,   0,   0,   0,   0, 1, 0,        0, 1);  // each field past grid
      add_row(4,   0,  16,   0,   0,   0,   0, 1, 0,        0, 1);
      add_row(4,   0,   0,  16,   0,   0,   0, 1, 0,        0, 1);
      add_row(4,   0,   0,   0,  16,   0,   0, 1, 0,        0, 1);
      add_row(4,   0,   0,   0,   0,  16,   0, 1, 0,        0, 1);
      add_row(4,   0,   0,   0,   0,   0, 255, 1, 0,        0, 1);
      add_row(4,  15,  15,  15,  15,  15,  15, 1, 4680,     4, 0);
      add_row(4,   1,   2,   3,   5,   2,   3, 0, 0,        0, 0);
      add_row(9,  12,  34,  56,  12,  35,  60, 0, 0,        0, 0);
      add_row(7, 127,   0, 127,   0, 127,   0, 0, 0,        0, 0);
      add_row(7,  64,  64,  64,  64,  64,  64, 0, 0,        0, 0);

      foreach (box_table[i]) begin
         if (box_table[i].lv != levels_reg) begin
            drain_results();
            write_levels(box_table[i].lv);
         end
         send_box(box_table[i].box,
                  box_table[i].typed ? box_table[i].want
                                     : predict_cell(box_table[i].box, levels_reg),
                  pick_gap());
      end

      // Random phases: extremes first, then random settings biased to the legal range.
      phase_lv = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3};
      repeat (7) begin
         if ($urandom_range(0, 9) < 7) phase_lv.push_back(LEVEL_W'($urandom_range(1, MAX_LV)));
         else phase_lv.push_back(LEVEL_W'($urandom_range(0, 15)));
      end
      n_items = 34;

      foreach (phase_lv[p]) begin
         drain_results();
         write_levels(phase_lv[p]);
         no_gaps = (p % 4 == 1);   // some phases run back to back
         for (int i = 0; i < n_items; i++) begin
            // sender pauses mid-phase until the pipe has emptied
            if (p == 2 && i == n_items / 2) drain_results();
            b = make_box(levels_reg);
            send_box(b, predict_cell(b, levels_reg), no_gaps ? 0 : pick_gap());
         end
      end

      drain_results();
      repeat (6) @(posedge clock);   // pipeline is 3 deep; catch stray strobes
      if (mismatch_count == 0 && pending_cells.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/locidx_pkg.sv
hw/rtl/locidx_interleave.sv
hw/rtl/locidx_prefix.sv
hw/rtl/locidx_offset_add.sv
hw/rtl/linear_octree_cell_index_unit.sv
tb/tb_linear_octree_cell_index_unit.sv
